/* hw/rtl/time_bucket_bounds_core_assert.svh */
// Assertion macros shared by the checker of the time bucket core
`ifndef TIME_BUCKET_BOUNDS_CORE_ASSERT_SVH
`define TIME_BUCKET_BOUNDS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TBB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbb: assertion failed");

// next-cycle implication
`define TBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbb: assertion failed");

`endif

/* hw/rtl/tbb_pkg.sv */
// Package: field widths, bar codes, queue word and calendar helpers
package tbb_pkg;

  localparam int CODE_W  = 4;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;

  // year / 25 by reciprocal: ceil(2^19 / 25), exact for every 14-bit year
  localparam int Y25_SHIFT = 19;
  localparam int Y25_RECIP = 20972;
  localparam int RECIP_W   = 15;
  localparam int PROD_W    = YEAR_W + RECIP_W;
  localparam int QY_W      = PROD_W - Y25_SHIFT;

  // queue between front and back; depth kept a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // bar length codes
  localparam logic [CODE_W-1:0] BAR_MIN1   = 4'd0;
  localparam logic [CODE_W-1:0] BAR_MIN5   = 4'd1;
  localparam logic [CODE_W-1:0] BAR_MIN10  = 4'd2;
  localparam logic [CODE_W-1:0] BAR_MIN15  = 4'd3;
  localparam logic [CODE_W-1:0] BAR_MIN30  = 4'd4;
  localparam logic [CODE_W-1:0] BAR_MIN60  = 4'd5;
  localparam logic [CODE_W-1:0] BAR_DAY    = 4'd6;
  localparam logic [CODE_W-1:0] BAR_WEEK   = 4'd7;
  localparam logic [CODE_W-1:0] BAR_MONTH  = 4'd8;

  // word handed from front to back
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [QY_W-1:0]    qy;      // year / 25
    logic               pre_ok;  // code and field ranges fine
  } tbb_item_t;

  // result word
  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [HOUR_W-1:0]  start_hour;
    logic [MIN_W-1:0]   start_minute;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic [HOUR_W-1:0]  end_hour;
    logic [MIN_W-1:0]   end_minute;
    logic [MIN_W-1:0]   end_second;
    logic               valid_res;
  } tbb_res_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                               n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:            n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                       n = 5'd31;
      default:                            n = 5'd0;
    endcase
    return n;
  endfunction

  // days of a common year before the first of month m
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [MIN_W-1:0] bar_step(input logic [CODE_W-1:0] code);
    logic [MIN_W-1:0] st;
    case (code)
      BAR_MIN1:  st = 6'd1;
      BAR_MIN5:  st = 6'd5;
      BAR_MIN10: st = 6'd10;
      BAR_MIN15: st = 6'd15;
      BAR_MIN30: st = 6'd30;
      BAR_MIN60: st = 6'd60;
      default:   st = 6'd0;
    endcase
    return st;
  endfunction

endpackage

/* hw/rtl/tbb_front.sv */
// Front: accepts input words, range checks them, takes year / 25
module tbb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tbb_pkg::CODE_W-1:0]    bar_length_i,
  input  logic [tbb_pkg::YEAR_W-1:0]    year_i,
  input  logic [tbb_pkg::MONTH_W-1:0]   month_i,
  input  logic [tbb_pkg::DAY_W-1:0]     day_i,
  input  logic [tbb_pkg::HOUR_W-1:0]    hour_i,
  input  logic [tbb_pkg::MIN_W-1:0]     minute_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tbb_pkg::tbb_item_t            item_o
);
  import tbb_pkg::*;

  logic              valid_q, valid_d;
  tbb_item_t         item_q, item_d;
  logic              accept;
  logic [PROD_W-1:0] prod;

  assign in_stall_o = valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~q_full_i;
  assign valid_d    = accept | (valid_q & ~push_o);
  assign prod       = PROD_W'(year_i) * PROD_W'(Y25_RECIP);

  always_comb begin
    item_d.code   = bar_length_i;
    item_d.year   = year_i;
    item_d.month  = month_i;
    item_d.day    = day_i;
    item_d.hour   = hour_i;
    item_d.minute = minute_i;
    item_d.qy     = prod[Y25_SHIFT +: QY_W];
    item_d.pre_ok = (bar_length_i <= BAR_MONTH) && (year_i != '0) && (year_i <= YEAR_MAX) &&
                    (month_i != '0) && (month_i <= MONTH_DEC) && (day_i != '0) &&
                    (hour_i <= 5'd23) && (minute_i <= 6'd59);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

/* hw/rtl/tbb_queue.sv */
// Two-word queue between front and back
module tbb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tbb_pkg::tbb_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output tbb_pkg::tbb_item_t item_o
);
  import tbb_pkg::*;

  tbb_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointers wrap on overflow (power-of-two depth)
  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/tbb_back.sv */
// Back: three-stage calendar pipeline producing bucket start and end
module tbb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               pop_o,
  input  tbb_pkg::tbb_item_t item_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output tbb_pkg::tbb_res_t  res_o
);
  import tbb_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   sn;
    logic [13:0]        wsum;   // weekday sum, taken mod 7 in stage B
    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic               ok;
  } stage_a_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  sy;
    logic [MONTH_W-1:0] sm;
    logic [DAY_W-1:0]   sd;
    logic [HOUR_W-1:0]  sh;
    logic [MIN_W-1:0]   sn;
    logic [HOUR_W-1:0]  eh;
    logic [MIN_W-1:0]   en;
    logic [MIN_W-1:0]   es;
    logic [2:0]         fwd;    // days from start to end date
    logic               mon;
    logic [DAY_W-1:0]   dims;   // length of the start month
    logic               ok;
  } stage_b_t;

  logic     a_valid_q, b_valid_q, c_valid_q;
  logic     adv_a, adv_b, adv_c;
  stage_a_t a_q, a_d;
  stage_b_t b_q, b_d;
  tbb_res_t c_q, c_d;

  // pipeline flow
  assign adv_c       = ~c_valid_q | ~out_stall_i;
  assign adv_b       = ~b_valid_q | adv_c;
  assign adv_a       = ~a_valid_q | adv_b;
  assign pop_o       = q_valid_i & adv_a;
  assign out_valid_o = c_valid_q;
  assign res_o       = c_q;

  // ---------------- stage A: leap year, date check, weekday sum, minute floor
  logic [14:0]       y25, rem;
  logic              r_zero, y100z, y400z, leap_a;
  logic [DAY_W-1:0]  dim_a;
  logic [YEAR_W-1:0] pm1;
  logic [7:0]        q100p;
  logic [5:0]        q400p;
  logic [8:0]        doy;
  logic [14:0]       s_sum;
  logic [13:0]       m205;
  logic [12:0]       m69;
  logic [3:0]        q5;
  logic [2:0]        q15;
  logic [MIN_W-1:0]  sn_a;

  always_comb begin
    y25    = 15'({item_i.qy, 4'b0}) + 15'({item_i.qy, 3'b0}) + 15'(item_i.qy);
    rem    = 15'(item_i.year) - y25;
    r_zero = (rem == '0);
    y100z  = r_zero && (item_i.qy[1:0] == 2'd0);
    y400z  = r_zero && (item_i.qy[3:0] == 4'd0);
    leap_a = ((item_i.year[1:0] == 2'd0) && !y100z) || y400z;
    dim_a  = month_days(item_i.month, leap_a);

    // days since 0001-01-01 reduced: 365 = 1 (mod 7)
    pm1    = item_i.year - 1'b1;
    q100p  = 8'(item_i.qy[QY_W-1:2]) - 8'(y100z);
    q400p  = 6'(item_i.qy[QY_W-1:4]) - 6'(y400z);
    doy    = days_before(item_i.month) + 9'(leap_a && (item_i.month > MONTH_FEB)) +
             9'(item_i.day) - 9'd1;
    s_sum  = 15'(pm1) + 15'(pm1[YEAR_W-1:2]) - 15'(q100p) + 15'(q400p) +
             15'(doy) + 15'd1;

    // minute / 5 and / 15 by reciprocal
    m205 = 14'(item_i.minute) * 14'd205;
    m69  = 13'(item_i.minute) * 13'd69;
    q5   = m205[13:10];
    q15  = m69[12:10];
    case (item_i.code)
      BAR_MIN1:  sn_a = item_i.minute;
      BAR_MIN5:  sn_a = 6'({q5, 2'b0}) + 6'(q5);
      BAR_MIN10: sn_a = 6'({q5[3:1], 3'b0}) + 6'({q5[3:1], 1'b0});
      BAR_MIN15: sn_a = 6'({q15, 4'b0}) - 6'(q15);
      BAR_MIN30: sn_a = 6'({q15[2:1], 5'b0}) - 6'({q15[2:1], 1'b0});
      default:   sn_a = '0;
    endcase

    a_d.code  = item_i.code;
    a_d.year  = item_i.year;
    a_d.month = item_i.month;
    a_d.day   = item_i.day;
    a_d.hour  = item_i.hour;
    a_d.sn    = sn_a;
    a_d.wsum  = s_sum[13:0];
    a_d.leap  = leap_a;
    a_d.dim   = dim_a;
    a_d.ok    = item_i.pre_ok && (item_i.day <= dim_a);
  end

  // ---------------- stage B: weekday, bucket start, minute end
  logic [4:0]         a5;
  logic [3:0]         t7;
  logic [2:0]         wd;
  logic               borrow;
  logic [MONTH_W-1:0] pm;
  logic [DAY_W-1:0]   dim_prev, sd_wk;
  logic [MIN_W-1:0]   st;
  logic [6:0]         en_raw;
  logic               wrap, dwrap;
  logic [HOUR_W-1:0]  eh_raw;

  always_comb begin
    // mod 7 by folding octal digits (8 = 1 mod 7)
    a5 = 5'(a_q.wsum[2:0]) + 5'(a_q.wsum[5:3]) + 5'(a_q.wsum[8:6]) +
         5'(a_q.wsum[11:9]) + 5'(a_q.wsum[13:12]);
    t7 = 4'(a5[2:0]) + 4'(a5[4:3]);
    wd = (t7 >= 4'd7) ? 3'(t7 - 4'd7) : t7[2:0];

    borrow   = (a_q.day <= 5'(wd));
    pm       = (a_q.month == MONTH_JAN) ? MONTH_DEC : a_q.month - 1'b1;
    dim_prev = month_days(pm, a_q.leap);
    sd_wk    = borrow ? 5'(6'(a_q.day) + 6'(dim_prev) - 6'(wd)) : a_q.day - 5'(wd);

    st     = bar_step(a_q.code);
    en_raw = 7'(a_q.sn) + 7'(st);
    wrap   = (en_raw >= 7'd60);
    eh_raw = a_q.hour + 5'(wrap);
    dwrap  = (eh_raw >= 5'd24);

    b_d.sy   = a_q.year;
    b_d.sm   = a_q.month;
    b_d.sd   = a_q.day;
    b_d.sh   = '0;
    b_d.sn   = '0;
    b_d.eh   = 5'd23;
    b_d.en   = 6'd59;
    b_d.es   = 6'd59;
    b_d.fwd  = '0;
    b_d.mon  = 1'b0;
    b_d.dims = a_q.dim;
    b_d.ok   = a_q.ok;
    case (a_q.code)
      BAR_MIN1, BAR_MIN5, BAR_MIN10, BAR_MIN15, BAR_MIN30, BAR_MIN60: begin
        b_d.sh  = a_q.hour;
        b_d.sn  = a_q.sn;
        b_d.en  = wrap ? 6'(en_raw - 7'd60) : en_raw[MIN_W-1:0];
        b_d.eh  = dwrap ? '0 : eh_raw;
        b_d.es  = '0;
        b_d.fwd = 3'(dwrap);
      end
      BAR_DAY: begin
        b_d.fwd = '0;
      end
      BAR_WEEK: begin
        // Sunday opens its week; otherwise step back wd days
        b_d.sy   = (borrow && (a_q.month == MONTH_JAN)) ? a_q.year - 1'b1 : a_q.year;
        b_d.sm   = borrow ? pm : a_q.month;
        b_d.sd   = sd_wk;
        b_d.dims = borrow ? dim_prev : a_q.dim;
        b_d.fwd  = 3'd6;
      end
      BAR_MONTH: begin
        b_d.sd  = 5'd1;
        b_d.mon = 1'b1;
      end
      default: begin
        b_d.ok = 1'b0;
      end
    endcase
  end

  // ---------------- stage C: end date, year range, result word
  logic [5:0]         ed_raw;
  logic               roll, ok_c;
  logic [DAY_W-1:0]   ed;
  logic [MONTH_W-1:0] em;
  logic [YEAR_W-1:0]  ey;

  always_comb begin
    ed_raw = 6'(b_q.sd) + 6'(b_q.fwd);
    roll   = (ed_raw > 6'(b_q.dims));
    ed     = b_q.mon ? b_q.dims : (roll ? 5'(ed_raw - 6'(b_q.dims)) : ed_raw[DAY_W-1:0]);
    em     = roll ? ((b_q.sm == MONTH_DEC) ? MONTH_JAN : b_q.sm + 1'b1) : b_q.sm;
    ey     = (roll && (b_q.sm == MONTH_DEC)) ? b_q.sy + 1'b1 : b_q.sy;
    ok_c   = b_q.ok && (b_q.sy != '0) && (ey <= YEAR_MAX);

    c_d = '0;
    if (ok_c) begin
      c_d.start_year   = b_q.sy;
      c_d.start_month  = b_q.sm;
      c_d.start_day    = b_q.sd;
      c_d.start_hour   = b_q.sh;
      c_d.start_minute = b_q.sn;
      c_d.end_year     = ey;
      c_d.end_month    = em;
      c_d.end_day      = ed;
      c_d.end_hour     = b_q.eh;
      c_d.end_minute   = b_q.en;
      c_d.end_second   = b_q.es;
      c_d.valid_res    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= q_valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
      if (adv_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_q <= a_d;
    end
    if (adv_b) begin
      b_q <= b_d;
    end
    if (adv_c) begin
      c_q <= c_d;
    end
  end

endmodule

/* hw/rtl/time_bucket_bounds_core.sv */
// Top level of the time bucket core: start and end of the bar holding a timestamp
//
// Input channel (in_valid_i / in_stall_o): one word per timestamp, carrying the
// bar code and year, month, day, hour, minute. A word is taken on a rising edge
// with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): exactly one result word per input
// word, in order: bucket start, bucket end, and valid_res. When valid_res is low
// (unknown code, malformed date-time, or a bucket outside years 1..9999) every
// other field is zero.
// Throughput: one word per cycle while out_stall_i is low; the minute floor,
// weekday and calendar steps are spread over the three back stages, each a single
// pass per word.
// Front register feeds a two-word queue; the back pipeline pops from it. A stall
// on the output holds the back stages, then fills the queue, and only then
// raises in_stall_o; a held result does not change.
// Reset (rst_ni low, asynchronous) empties every stage and the queue; no
// clearing pass follows.
module time_bucket_bounds_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tbb_pkg::CODE_W-1:0]   bar_length_i,
  input  logic [tbb_pkg::YEAR_W-1:0]   year_i,
  input  logic [tbb_pkg::MONTH_W-1:0]  month_i,
  input  logic [tbb_pkg::DAY_W-1:0]    day_i,
  input  logic [tbb_pkg::HOUR_W-1:0]   hour_i,
  input  logic [tbb_pkg::MIN_W-1:0]    minute_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tbb_pkg::YEAR_W-1:0]   start_year_o,
  output logic [tbb_pkg::MONTH_W-1:0]  start_month_o,
  output logic [tbb_pkg::DAY_W-1:0]    start_day_o,
  output logic [tbb_pkg::HOUR_W-1:0]   start_hour_o,
  output logic [tbb_pkg::MIN_W-1:0]    start_minute_o,
  output logic [tbb_pkg::YEAR_W-1:0]   end_year_o,
  output logic [tbb_pkg::MONTH_W-1:0]  end_month_o,
  output logic [tbb_pkg::DAY_W-1:0]    end_day_o,
  output logic [tbb_pkg::HOUR_W-1:0]   end_hour_o,
  output logic [tbb_pkg::MIN_W-1:0]    end_minute_o,
  output logic [tbb_pkg::MIN_W-1:0]    end_second_o,
  output logic                         valid_res_o
);
  import tbb_pkg::*;

  // front to queue
  logic      push, q_full;
  tbb_item_t front_item;
  // queue to back
  logic      q_valid, pop;
  tbb_item_t back_item;
  tbb_res_t  res;

  tbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .bar_length_i (bar_length_i),
    .year_i       (year_i),
    .month_i      (month_i),
    .day_i        (day_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  tbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (back_item)
  );

  tbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .pop_o       (pop),
    .item_i      (back_item),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  // result word onto the output ports
  assign start_year_o   = res.start_year;
  assign start_month_o  = res.start_month;
  assign start_day_o    = res.start_day;
  assign start_hour_o   = res.start_hour;
  assign start_minute_o = res.start_minute;
  assign end_year_o     = res.end_year;
  assign end_month_o    = res.end_month;
  assign end_day_o      = res.end_day;
  assign end_hour_o     = res.end_hour;
  assign end_minute_o   = res.end_minute;
  assign end_second_o   = res.end_second;
  assign valid_res_o    = res.valid_res;

endmodule

/* hw/rtl/tbb_checker.sv */
// Port checker for the time bucket core, bound to the top level
`include "time_bucket_bounds_core_assert.svh"

module tbb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [tbb_pkg::YEAR_W-1:0]   start_year_o,
  input logic [tbb_pkg::MONTH_W-1:0]  start_month_o,
  input logic [tbb_pkg::DAY_W-1:0]    start_day_o,
  input logic [tbb_pkg::HOUR_W-1:0]   start_hour_o,
  input logic [tbb_pkg::MIN_W-1:0]    start_minute_o,
  input logic [tbb_pkg::YEAR_W-1:0]   end_year_o,
  input logic [tbb_pkg::MONTH_W-1:0]  end_month_o,
  input logic [tbb_pkg::DAY_W-1:0]    end_day_o,
  input logic [tbb_pkg::HOUR_W-1:0]   end_hour_o,
  input logic [tbb_pkg::MIN_W-1:0]    end_minute_o,
  input logic [tbb_pkg::MIN_W-1:0]    end_second_o,
  input logic                         valid_res_o
);
  import tbb_pkg::*;

  tbb_res_t out_word;
  logic     day_bar, day_bounds;

  assign out_word   = {start_year_o, start_month_o, start_day_o, start_hour_o, start_minute_o,
                       end_year_o, end_month_o, end_day_o, end_hour_o, end_minute_o,
                       end_second_o, valid_res_o};
  assign day_bar    = valid_res_o && (end_second_o == 6'd59);
  assign day_bounds = (start_hour_o == 5'd0) && (start_minute_o == 6'd0) &&
                      (end_hour_o == 5'd23) && (end_minute_o == 6'd59);

  // a stalled result stays offered
  `TBB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // and does not change
  `TBB_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

  // input back-pressure only after the output has held things up
  `TBB_ASSERT_SAME(a_stall_cause, $rose(in_stall_o), $past(out_stall_i))

  // a rejected word carries no dates
  `TBB_ASSERT_SAME(a_invalid_zero, out_valid_o && !valid_res_o, out_word == '0)

  // day, week and month bars run from midnight to 23:59:59
  `TBB_ASSERT_SAME(a_day_shape, out_valid_o && day_bar, day_bounds)

endmodule

bind time_bucket_bounds_core tbb_checker u_tbb_checker (.*);
